/* src/hett_pkg.sv */
// Shared types and constants for the expert heat tier table.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package hett_pkg;

	// Opcodes carried in the input tuser field.
	localparam logic [1:0] OP_RECORD = 2'd0;
	localparam logic [1:0] OP_QUERY  = 2'd1;
	localparam logic [1:0] OP_DECAY  = 2'd2;
	localparam logic [1:0] OP_CLEAR  = 2'd3;

	// Tier codes of a result.
	localparam logic [1:0] TIER_COLD = 2'd0;
	localparam logic [1:0] TIER_WARM = 2'd1;
	localparam logic [1:0] TIER_HOT  = 2'd2;

	// Configuration register indexes.
	localparam logic REG_HOT  = 1'b0;
	localparam logic REG_WARM = 1'b1;

	localparam int CNT_W    = 32;
	localparam int FACTOR_W = 9;
	localparam int IN_W     = 24;
	localparam int OUT_W    = 40;

	localparam logic [CNT_W-1:0]    COUNT_MAX   = '1;
	localparam logic [FACTOR_W-1:0] FACTOR_ONE  = 9'd256;
	localparam logic [CNT_W-1:0]    HOT_RESET   = 32'd100;
	localparam logic [CNT_W-1:0]    WARM_RESET  = 32'd10;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;     // item taken: latch it and read its counter
		logic walk_issue; // read the entry under the walk pointer
		logic walk_zero;  // the issued entry is written with zero
		logic rmw_done;   // finish a record or query and load its result
		logic walk_done;  // load the zero result of a decay or clear
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [1:0] op;        // opcode of the held item
		logic       walk_last; // walk pointer is at the last entry
		logic       out_free;  // output register can take a word
		logic       wr_pend;   // a walk write is still in flight
	} status_t;

endpackage

`default_nettype wire

/* src/hett_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module hett_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  wire logic                                        clk,
	input  wire logic                                        we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                            wdata,
	input  wire logic                                        re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* src/hett_ctrl.sv */
// Controller state machine of the expert heat tier table.
// Depends on hett_pkg for the command and status structs and opcodes.
`default_nettype none

module hett_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	input  wire logic [1:0]       s_op,
	output logic                  s_tready,
	input  wire hett_pkg::status_t sts,
	output hett_pkg::cmd_t        cmd
);

	typedef enum logic [5:0] {
		ST_INIT   = 6'b000001,
		ST_SETTLE = 6'b000010,
		ST_IDLE   = 6'b000100,
		ST_RMW    = 6'b001000,
		ST_WALK   = 6'b010000,
		ST_DONE   = 6'b100000
	} state_t;

	state_t state_q, state_d;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		unique case (state_q)
			ST_INIT: begin
				// Clearing pass after reset.
				cmd.walk_issue = 1'b1;
				cmd.walk_zero  = 1'b1;
				if (sts.walk_last) begin
					state_d = ST_SETTLE;
				end
			end
			ST_SETTLE: begin
				state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					if (s_op == hett_pkg::OP_RECORD || s_op == hett_pkg::OP_QUERY) begin
						state_d = ST_RMW;
					end else begin
						state_d = ST_WALK;
					end
				end
			end
			ST_RMW: begin
				if (sts.out_free) begin
					cmd.rmw_done = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_WALK: begin
				cmd.walk_issue = 1'b1;
				cmd.walk_zero  = (sts.op == hett_pkg::OP_CLEAR);
				if (sts.walk_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.walk_done = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_INIT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

/* src/hett_dp.sv */
// Datapath of the expert heat tier table: item registers, counter RAM, walk
// pipeline, decay multiplier, tier compare and output register.
// Depends on hett_pkg and hett_ram.
`default_nettype none

module hett_dp #(
	parameter int NUM_LAYERS  = 32,
	parameter int NUM_EXPERTS = 128
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [1:0]                    s_op,
	input  wire logic [4:0]                    s_layer,
	input  wire logic [6:0]                    s_expert,
	input  wire logic [hett_pkg::FACTOR_W-1:0] s_factor,
	input  wire logic                          cfg_valid,
	input  wire logic                          cfg_index,
	input  wire logic [hett_pkg::CNT_W-1:0]    cfg_data,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic      [hett_pkg::OUT_W-1:0]    m_tdata,
	input  wire hett_pkg::cmd_t                cmd,
	output hett_pkg::status_t                  sts
);

	localparam int DEPTH = NUM_LAYERS * NUM_EXPERTS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = hett_pkg::CNT_W;
	localparam int FW    = hett_pkg::FACTOR_W;
	localparam int PW    = CW + FW;
	localparam logic [AW-1:0] NE_A   = AW'(NUM_EXPERTS);
	localparam logic [AW-1:0] LAST_A = AW'(DEPTH - 1);

	logic [CW-1:0] hot_q, warm_q;
	logic [1:0]    op_q;
	logic          in_range_q;
	logic [AW-1:0] addr_q;
	logic [FW-1:0] factor_q;
	logic [AW-1:0] ptr_q;
	logic          wr_s1;
	logic          zero_s1;
	logic [AW-1:0] waddr_s1;
	logic          m_valid_q;
	logic [CW-1:0] m_count_q;
	logic [1:0]    m_tier_q;

	logic          in_range_c;
	logic [AW-1:0] addr_c;
	logic          ram_re, ram_we;
	logic [AW-1:0] ram_raddr, ram_waddr;
	logic [CW-1:0] ram_wdata, rd_data;
	logic [CW-1:0] cur_c, new_c;
	logic          inc_c;
	logic [PW-1:0] prod_c;
	logic [1:0]    tier_c;

	assign in_range_c = (32'(s_layer) < 32'(NUM_LAYERS)) && (32'(s_expert) < 32'(NUM_EXPERTS));
	assign addr_c     = AW'(s_layer) * NE_A + AW'(s_expert);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hot_q  <= hett_pkg::HOT_RESET;
			warm_q <= hett_pkg::WARM_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				hett_pkg::REG_HOT:  hot_q  <= cfg_data;
				hett_pkg::REG_WARM: warm_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Held item; the decay factor is capped at 1.0 on the way in.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q       <= s_op;
			in_range_q <= in_range_c;
			addr_q     <= addr_c;
			factor_q   <= (s_factor > hett_pkg::FACTOR_ONE) ? hett_pkg::FACTOR_ONE : s_factor;
		end
	end

	// Walk pointer and the write stage, which writes each entry in the cycle after its read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
			wr_s1 <= 1'b0;
		end else begin
			wr_s1 <= cmd.walk_issue;
			if (cmd.walk_issue) begin
				ptr_q <= (ptr_q == LAST_A) ? '0 : ptr_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.walk_issue) begin
			waddr_s1 <= ptr_q;
			zero_s1  <= cmd.walk_zero;
		end
	end

	// Record and query update.
	assign cur_c = in_range_q ? rd_data : '0;
	assign inc_c = (op_q == hett_pkg::OP_RECORD) && in_range_q && (cur_c != hett_pkg::COUNT_MAX);
	assign new_c = inc_c ? cur_c + CW'(1) : cur_c;

	// Decay: floor(count * factor / 256); the factor never exceeds 1.0.
	assign prod_c = PW'(rd_data) * PW'(factor_q);

	assign ram_re    = cmd.walk_issue || cmd.accept;
	assign ram_raddr = cmd.walk_issue ? ptr_q : addr_c;
	assign ram_we    = wr_s1 || (cmd.rmw_done && inc_c);
	assign ram_waddr = wr_s1 ? waddr_s1 : addr_q;
	always_comb begin
		if (!wr_s1) begin
			ram_wdata = new_c;
		end else if (zero_s1) begin
			ram_wdata = '0;
		end else begin
			ram_wdata = prod_c[CW+7:8];
		end
	end

	hett_ram #(
		.WIDTH(CW),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(rd_data)
	);

	// The hot test comes first.
	always_comb begin
		if (new_c > hot_q) begin
			tier_c = hett_pkg::TIER_HOT;
		end else if (new_c > warm_q) begin
			tier_c = hett_pkg::TIER_WARM;
		end else begin
			tier_c = hett_pkg::TIER_COLD;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.rmw_done || cmd.walk_done) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rmw_done) begin
			m_count_q <= new_c;
			m_tier_q  <= tier_c;
		end else if (cmd.walk_done) begin
			m_count_q <= '0;
			m_tier_q  <= hett_pkg::TIER_COLD;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {(hett_pkg::OUT_W - CW - 2)'(0), m_tier_q, m_count_q};

	assign sts.op        = op_q;
	assign sts.walk_last = (ptr_q == LAST_A);
	assign sts.out_free  = !m_valid_q || m_tready;
	assign sts.wr_pend   = wr_s1;

endmodule

`default_nettype wire

/* src/expert_heat_tier_table_top.sv */
// Top level of the expert heat tier table: a table of saturating access
// counters per (layer, expert) pair with record, query, decay and clear.
//
// Channels: the s_ group takes one word per operation, the m_ group gives
// one result word per operation, and the cfg_ group writes the hot (index 0)
// and warm (index 1) thresholds; cfg_ready is always high. Thresholds may be
// written only while no operation is in flight.
// Record and query read the addressed counter from the counter RAM in the
// cycle the word is taken and write it back when the result is loaded into
// the output register; a new word is taken only after the last one is done.
// The RAM read is registered: the count arrives in the cycle after its
// address, and the write-back must land before the next read.
// Decay and clear walk every entry, one per cycle, with the write landing in
// the cycle after the read, and return a result word holding zero count
// and the cold tier.
// After reset the block runs a clearing pass over the same walk; s_tready
// stays low meanwhile, while threshold writes are still taken.
// The result sits in an output register. If the receiver stalls, the word
// holds there and the next operation may still be taken; it waits only when
// its own result is due and the register is still full.
// Depends on hett_pkg, hett_ctrl, hett_dp and hett_ram.
`default_nettype none

module expert_heat_tier_table_top #(
	parameter int NUM_LAYERS  = 32,
	parameter int NUM_EXPERTS = 128
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input word.
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,  // layer_index[4:0], expert_index[11:5], decay_factor[20:12]
	input  wire logic [1:0]  s_tuser,  // opcode[1:0]
	// Result word.
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [39:0] m_tdata,  // access_count[31:0], tier[33:32]
	// Threshold writes.
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_data
);

	hett_pkg::cmd_t    cmd;
	hett_pkg::status_t sts;

	assign cfg_ready = 1'b1;

	hett_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_op    (s_tuser),
		.s_tready(s_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	hett_dp #(
		.NUM_LAYERS (NUM_LAYERS),
		.NUM_EXPERTS(NUM_EXPERTS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_op     (s_tuser),
		.s_layer  (s_tdata[4:0]),
		.s_expert (s_tdata[11:5]),
		.s_factor (s_tdata[20:12]),
		.cfg_valid(cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cmd      (cmd),
		.sts      (sts)
	);

	// No walk write may still be in flight when a new word can be taken.
	a_no_pending_write: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !sts.wr_pend)
		else $error("walk write pending while accepting");

	// A result is loaded only into a free output register.
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.rmw_done || cmd.walk_done) |-> sts.out_free)
		else $error("result loaded into a full output register");

	// One operation at a time: the input is not ready in the cycle after a word is taken.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken on consecutive cycles");

endmodule

`default_nettype wire
